@@ rtl/ptd_pkg.sv @@
// Shared types and constants for the polynomial term deque.
`timescale 1ns / 1ps

package ptd_pkg;

  // Store depth and derived counter width (count must hold CAPACITY itself)
  localparam int CAPACITY    = 64;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int DEG_W       = 16;
  localparam int COEF_W      = 32;
  localparam int OUT_INDEX_W = 6;
  localparam int REMOVED_W   = 7;

  // Request codes; code 7 is unused
  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_REMOVE     = 3'd4,
    OP_FIND       = 3'd5,
    OP_COEF       = 3'd6
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // One stored term
  typedef struct packed {
    logic signed [DEG_W-1:0]  degree;
    logic signed [COEF_W-1:0] coef;
  } term_t;

  // What every cell does in a cycle
  typedef enum logic [2:0] {
    M_HOLD  = 3'd0,
    M_LEFT  = 3'd1,
    M_ROT   = 3'd2,
    M_RIGHT = 3'd3,
    M_WRITE = 3'd4
  } cell_mode_t;

  // Per-cell control: shared mode plus the cell's own tail and write selects
  typedef struct packed {
    cell_mode_t mode;
    logic       tail;
    logic       wr;
  } cell_ctl_t;

endpackage

@@ rtl/ptd_cell.sv @@
// One storage cell of the term chain: holds a term and trades with its neighbors.
`timescale 1ns / 1ps

module ptd_cell (
  input  logic              clk,
  input  ptd_pkg::cell_ctl_t ctl,
  input  ptd_pkg::term_t    head,
  input  ptd_pkg::term_t    fill,
  input  ptd_pkg::term_t    left_term,
  input  ptd_pkg::term_t    right_term,
  output ptd_pkg::term_t    term
);
  import ptd_pkg::*;

  term_t term_next;

  // Select the next content from the mode
  always_comb begin
    case (ctl.mode)
      M_HOLD:  term_next = term;
      M_LEFT:  term_next = right_term;
      M_ROT:   term_next = ctl.tail ? head : right_term;
      M_RIGHT: term_next = left_term;
      M_WRITE: term_next = ctl.wr ? fill : term;
      default: term_next = term;
    endcase
  end

  // Hold the term
  always_ff @(posedge clk) begin
    term <= term_next;
  end

endmodule

@@ rtl/polynomial_term_deque_unit.sv @@
// Top level of the polynomial term deque: request control and the cell chain.
//
// Usage:
//   Raise start with operation, in_degree and in_coef; the transaction is
//   taken at the clock edge where start is high and busy is low.
//   Each transaction yields exactly one result, shown on out_degree,
//   out_coef, out_index, removed_count and status for one cycle with done
//   high. The receiver cannot stall; a result must be taken when shown.
//   Terms live in a chain of CAPACITY cells, front term in cell 0.
//   Push back, push front, pop front and the unused code never go busy:
//   done follows in the next cycle and busy stays low, so such
//   requests may issue every cycle.
//   Pop back, remove all, find and coefficient-of-degree walk the stored
//   terms by rotating the chain one cell per cycle (a term taken out is
//   shifted out instead): busy stays high for the walk, done comes in the
//   cycle busy falls. With no terms stored, done follows in the next cycle.
//   The rate is set by the chain rotation: one stored term per cycle.
//   Reset (rst, synchronous) empties the deque; cell contents are not
//   cleared and are never read before being written.
`timescale 1ns / 1ps

module polynomial_term_deque_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [2:0]                          operation,
  input  logic signed [ptd_pkg::DEG_W-1:0]    in_degree,
  input  logic signed [ptd_pkg::COEF_W-1:0]   in_coef,
  output logic                                done,
  output logic signed [ptd_pkg::DEG_W-1:0]    out_degree,
  output logic signed [ptd_pkg::COEF_W-1:0]   out_coef,
  output logic [ptd_pkg::OUT_INDEX_W-1:0]     out_index,
  output logic [ptd_pkg::REMOVED_W-1:0]       removed_count,
  output logic [1:0]                          status
);
  import ptd_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t state, state_next;

  // Control and scan registers
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  total, total_next;
  logic [CNT_W-1:0]  step, step_next;
  logic [CNT_W-1:0]  idx, idx_next;
  logic [CNT_W-1:0]  rem, rem_next;
  logic              found, found_next;
  logic [COEF_W-1:0] fcoef, fcoef_next;
  op_t               op_r, op_r_next;
  term_t             key, key_next;

  // Result next values
  logic                     done_next;
  logic [DEG_W-1:0]         out_degree_next;
  logic [COEF_W-1:0]        out_coef_next;
  logic [OUT_INDEX_W-1:0]   out_index_next;
  logic [REMOVED_W-1:0]     removed_count_next;
  status_t                  status_next;

  // Chain signals
  cell_mode_t mode;
  term_t      terms [CAPACITY];
  term_t      head;
  term_t      fill;

  logic accept;
  op_t  op_in;
  logic full;
  logic last;
  logic match_full;
  logic match_deg;

  logic [CNT_W+OUT_INDEX_W-1:0] idx_wide;
  logic [CNT_W+REMOVED_W-1:0]   rem_wide;

  assign busy       = (state != S_IDLE);
  assign accept     = start && (state == S_IDLE);
  assign op_in      = op_t'(operation);
  assign fill       = '{degree: in_degree, coef: in_coef};
  assign head       = terms[0];
  assign full       = (count == CNT_W'(CAPACITY));
  assign last       = (step == total - CNT_W'(1));
  assign match_full = (head.degree == key.degree) && (head.coef == key.coef);
  assign match_deg  = (head.degree == key.degree);
  assign idx_wide   = {{OUT_INDEX_W{1'b0}}, idx_next};
  assign rem_wide   = {{REMOVED_W{1'b0}}, rem_next};

  // Build the cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_ctl_t ctl;
    term_t     left_term;
    term_t     right_term;

    assign ctl.mode = mode;
    assign ctl.tail = (CNT_W'(i) == count - CNT_W'(1));
    assign ctl.wr   = (CNT_W'(i) == count);

    if (i == 0) begin : g_first
      assign left_term = fill;
    end else begin : g_mid_l
      assign left_term = terms[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_term = head;
    end else begin : g_mid_r
      assign right_term = terms[i+1];
    end

    ptd_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .head       (head),
      .fill       (fill),
      .left_term  (left_term),
      .right_term (right_term),
      .term       (terms[i])
    );
  end

  // Decode requests and advance the scan
  always_comb begin
    state_next         = state;
    mode               = M_HOLD;
    count_next         = count;
    total_next         = total;
    step_next          = step;
    idx_next           = idx;
    rem_next           = rem;
    found_next         = found;
    fcoef_next         = fcoef;
    op_r_next          = op_r;
    key_next           = key;
    done_next          = 1'b0;
    out_degree_next    = '0;
    out_coef_next      = '0;
    out_index_next     = '0;
    removed_count_next = '0;
    status_next        = ST_OK;

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (op_in)
            OP_PUSH_BACK, OP_PUSH_FRONT: begin
              done_next = 1'b1;
              if (full) begin
                status_next = ST_FULL;
              end else begin
                mode       = (op_in == OP_PUSH_BACK) ? M_WRITE : M_RIGHT;
                count_next = count + CNT_W'(1);
              end
            end
            OP_POP_FRONT: begin
              done_next = 1'b1;
              if (count == '0) begin
                status_next = ST_EMPTY;
              end else begin
                mode            = M_LEFT;
                count_next      = count - CNT_W'(1);
                out_degree_next = head.degree;
                out_coef_next   = head.coef;
              end
            end
            OP_POP_BACK, OP_REMOVE, OP_FIND, OP_COEF: begin
              if (count == '0) begin
                done_next = 1'b1;
                if (op_in == OP_POP_BACK) begin
                  status_next = ST_EMPTY;
                end else if (op_in == OP_FIND) begin
                  status_next = ST_NOTFOUND;
                end
              end else begin
                state_next = S_SCAN;
                op_r_next  = op_in;
                key_next   = fill;
                total_next = count;
                step_next  = '0;
                idx_next   = '0;
                rem_next   = '0;
                found_next = 1'b0;
                fcoef_next = '0;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Present element 'step' sits in cell 0
        case (op_r)
          OP_POP_BACK: begin
            if (last) begin
              mode       = M_LEFT;
              count_next = count - CNT_W'(1);
            end else begin
              mode = M_ROT;
            end
          end
          OP_REMOVE: begin
            if (match_full) begin
              mode       = M_LEFT;
              count_next = count - CNT_W'(1);
              rem_next   = rem + CNT_W'(1);
            end else begin
              mode = M_ROT;
            end
          end
          OP_FIND: begin
            mode = M_ROT;
            if (!found && match_full) begin
              found_next = 1'b1;
              idx_next   = step;
            end
          end
          OP_COEF: begin
            mode = M_ROT;
            if (!found && match_deg) begin
              found_next = 1'b1;
              fcoef_next = head.coef;
            end
          end
          default: begin
            mode = M_HOLD;
          end
        endcase

        step_next = step + CNT_W'(1);

        // Finish after the last stored term
        if (last) begin
          state_next = S_IDLE;
          done_next  = 1'b1;
          case (op_r)
            OP_POP_BACK: begin
              out_degree_next = head.degree;
              out_coef_next   = head.coef;
            end
            OP_REMOVE: begin
              removed_count_next = rem_wide[REMOVED_W-1:0];
            end
            OP_FIND: begin
              status_next    = found_next ? ST_OK : ST_NOTFOUND;
              out_index_next = found_next ? idx_wide[OUT_INDEX_W-1:0] : '0;
            end
            OP_COEF: begin
              out_coef_next = fcoef_next;
            end
            default: begin
              status_next = ST_OK;
            end
          endcase
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  // Hold scan registers and results
  always_ff @(posedge clk) begin
    total         <= total_next;
    step          <= step_next;
    idx           <= idx_next;
    rem           <= rem_next;
    found         <= found_next;
    fcoef         <= fcoef_next;
    op_r          <= op_r_next;
    key           <= key_next;
    out_degree    <= out_degree_next;
    out_coef      <= out_coef_next;
    out_index     <= out_index_next;
    removed_count <= removed_count_next;
    status        <= status_next;
  end

  // A result is only shown once the block is back to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE))
    else $error("result strobe while scanning");

  // The term count never exceeds the store
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("term count above capacity");

  // The scan step stays inside the stored terms
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (step < total))
    else $error("scan step past last term");

  // A push into a full store is flagged and leaves the count alone
  a_full_push: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && full &&
     (operation == OP_PUSH_BACK || operation == OP_PUSH_FRONT))
    |=> (done && (status == ST_FULL) && $stable(count)))
    else $error("full push not flagged");

  // Push and pop-front requests answer in the next cycle without going busy
  a_quick_ops: assert property (@(posedge clk) disable iff (rst)
    (start && !busy &&
     (operation == OP_PUSH_BACK || operation == OP_PUSH_FRONT ||
      operation == OP_POP_FRONT))
    |=> (done && !busy))
    else $error("single-cycle request did not answer");

endmodule
